/* rtl/core/nalsp_pkg.sv */
// Shared types and constants for the Annex B start-code splitter.
package nalsp_pkg;

  // Scanner phase
  typedef enum logic [1:0] {
    PH_LEAD,
    PH_BODY,
    PH_DROP
  } phase_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_UNIT,
    ST_NO_LEAD,
    ST_TRUNC
  } status_e;

  localparam logic [2:0]  CodeLenNone = 3'd0;
  localparam logic [2:0]  CodeLen3    = 3'd3;
  localparam logic [2:0]  CodeLen4    = 3'd4;
  localparam logic [7:0]  ByteZero    = 8'h00;
  localparam logic [7:0]  ByteOne     = 8'h01;
  localparam logic [23:0] WinOnes     = 24'hFFFFFF;
  localparam logic [23:0] OutLenMax   = 24'hFFFFFF;

  // One reported unit
  typedef struct packed {
    status_e     status;
    logic [15:0] unit_index;
    logic [31:0] stream_offset;
    logic [2:0]  start_code_length;
    logic        forbidden_flag;
    logic [1:0]  reference_priority;
    logic [4:0]  unit_type;
    logic [23:0] payload_length;
    logic        length_saturated;
  } result_t;

endpackage

/* rtl/core/nalsp_scan.sv */
// Byte scanner: start-code state, unit counters and result formation.
module nalsp_scan #(
  parameter int LENGTH_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        byte_i,
  input  logic              eos_i,
  output logic              res_valid_o,
  output nalsp_pkg::result_t res_o
);
  import nalsp_pkg::*;

  localparam int ExtW = (LENGTH_BITS > 24) ? LENGTH_BITS : 24;
  localparam logic [LENGTH_BITS-1:0] CntMax = '1;
  localparam logic [23:0] SatLen = (LENGTH_BITS >= 24) ? OutLenMax :
                                   24'((64'd1 << LENGTH_BITS) - 64'd1);

  phase_e                 phase_q, phase_d;
  logic [23:0]            win_q, win_d;
  logic [1:0]             prefix_q, prefix_d;
  logic [2:0]             code_q, code_d;
  logic [7:0]             hdr_q, hdr_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
  logic                   sat_q, sat_d;
  logic [31:0]            uoff_q, uoff_d;
  logic [31:0]            noff_q, noff_d;
  logic [15:0]            ucnt_q, ucnt_d;

  // body-phase datapath
  logic [7:0]             hdr_eff;
  logic [2:0]             found;
  logic                   cnt_top;
  logic [LENGTH_BITS-1:0] cnt_new;
  logic                   sat_new;
  logic [LENGTH_BITS:0]   diff;
  logic [LENGTH_BITS-1:0] len_lb;
  logic                   over;
  logic                   sat_fin;
  logic [23:0]            len_out;

  always_comb begin
    hdr_eff = (cnt_q == '0 && !sat_q) ? byte_i : hdr_q;
    found   = CodeLenNone;
    if (byte_i == ByteOne) begin
      if (win_q == '0) begin
        found = CodeLen4;
      end else if (win_q[15:0] == '0) begin
        found = CodeLen3;
      end
    end
    cnt_top = (cnt_q == CntMax);
    cnt_new = cnt_top ? cnt_q : cnt_q + 1'b1;
    sat_new = sat_q | cnt_top;
    // trailing start-code bytes come off the count, clamped at zero
    diff    = {1'b0, cnt_new} - (LENGTH_BITS+1)'(found);
    len_lb  = diff[LENGTH_BITS] ? '0 : diff[LENGTH_BITS-1:0];
    over    = ExtW'(len_lb) > ExtW'(OutLenMax);
    sat_fin = sat_new | over;
    len_out = sat_fin ? SatLen : 24'(len_lb);
  end

  // next state and result
  always_comb begin
    phase_d  = phase_q;
    win_d    = win_q;
    prefix_d = prefix_q;
    code_d   = code_q;
    hdr_d    = hdr_q;
    cnt_d    = cnt_q;
    sat_d    = sat_q;
    uoff_d   = uoff_q;
    ucnt_d   = ucnt_q;
    noff_d   = noff_q + 32'd1;

    res_valid_o               = 1'b0;
    res_o.status              = ST_UNIT;
    res_o.unit_index          = ucnt_q;
    res_o.stream_offset       = uoff_q;
    res_o.start_code_length   = CodeLenNone;
    res_o.forbidden_flag      = 1'b0;
    res_o.reference_priority  = 2'd0;
    res_o.unit_type           = 5'd0;
    res_o.payload_length      = '0;
    res_o.length_saturated    = 1'b0;

    case (phase_q)
      PH_LEAD: begin
        if (prefix_q >= 2'd2 && byte_i == ByteOne) begin
          // leading code complete, open the first unit
          code_d   = (prefix_q == 2'd2) ? CodeLen3 : CodeLen4;
          phase_d  = PH_BODY;
          uoff_d   = '0;
          win_d    = WinOnes;
          hdr_d    = '0;
          cnt_d    = '0;
          sat_d    = 1'b0;
          prefix_d = '0;
          if (eos_i) begin
            res_valid_o             = 1'b1;
            res_o.stream_offset     = '0;
            res_o.start_code_length = code_d;
            ucnt_d                  = ucnt_q + 16'd1;
          end
        end else if (prefix_q != 2'd3 && byte_i == ByteZero) begin
          prefix_d = prefix_q + 2'd1;
          if (eos_i) begin
            res_valid_o  = 1'b1;
            res_o.status = ST_TRUNC;
          end
        end else begin
          res_valid_o  = 1'b1;
          res_o.status = ST_NO_LEAD;
          phase_d      = PH_DROP;
        end
      end
      PH_BODY: begin
        hdr_d = hdr_eff;
        cnt_d = cnt_new;
        sat_d = sat_new;
        if (found != CodeLenNone || eos_i) begin
          res_valid_o              = 1'b1;
          res_o.start_code_length  = code_q;
          res_o.forbidden_flag     = hdr_eff[7];
          res_o.reference_priority = hdr_eff[6:5];
          res_o.unit_type          = hdr_eff[4:0];
          res_o.payload_length     = len_out;
          res_o.length_saturated   = sat_fin;
          ucnt_d                   = ucnt_q + 16'd1;
        end
        if (found != CodeLenNone) begin
          // next unit starts at the first byte of this start code
          code_d   = found;
          uoff_d   = noff_q - 32'(found) + 32'd1;
          win_d    = WinOnes;
          hdr_d    = '0;
          cnt_d    = '0;
          sat_d    = 1'b0;
          prefix_d = '0;
        end else if (!eos_i) begin
          win_d = {win_q[15:0], byte_i};
        end
      end
      PH_DROP: begin
      end
      default: begin
        phase_d = PH_DROP;
      end
    endcase

    // end of stream returns everything to the reset state
    if (eos_i) begin
      phase_d  = PH_LEAD;
      win_d    = WinOnes;
      prefix_d = '0;
      code_d   = CodeLen3;
      hdr_d    = '0;
      cnt_d    = '0;
      sat_d    = 1'b0;
      uoff_d   = '0;
      noff_d   = '0;
      ucnt_d   = '0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEAD;
      win_q    <= WinOnes;
      prefix_q <= '0;
      code_q   <= CodeLen3;
      hdr_q    <= '0;
      cnt_q    <= '0;
      sat_q    <= 1'b0;
      uoff_q   <= '0;
      noff_q   <= '0;
      ucnt_q   <= '0;
    end else if (en_i) begin
      phase_q  <= phase_d;
      win_q    <= win_d;
      prefix_q <= prefix_d;
      code_q   <= code_d;
      hdr_q    <= hdr_d;
      cnt_q    <= cnt_d;
      sat_q    <= sat_d;
      uoff_q   <= uoff_d;
      noff_q   <= noff_d;
      ucnt_q   <= ucnt_d;
    end
  end

endmodule

/* rtl/core/nal_unit_start_code_splitter.sv */
// Top level of the Annex B start-code splitter: stream ports and item registers.
//
// Input stream: one byte of an Annex B byte stream per item on s_axis;
// tlast marks the final byte of a stream. The stream must open with
// 00 00 01 or 00 00 00 01. Each unit is reported on m_axis when the next
// start code ends it or when the stream ends; a bad opening or a stream
// that ends inside its opening code gives one error item (tuser status),
// and bytes after a bad opening are dropped until tlast.
// Throughput: one byte per clock while m_axis does not hold results back.
// The scan state takes each byte as it leaves the input register, so each
// byte can follow the previous one directly. Path: a byte sits in the input
// register, and its result is loaded into the output register for m_axis.
// Stall: when m_axis_tready_i is low with a result pending, the input
// register holds its byte and s_axis_tready_o drops once that register is
// full; nothing is lost or repeated.
// Reset: all scan state returns to "expecting leading start code", both
// registers empty. After every tlast byte the scan state also resets, so a
// new stream may follow at once.
// LENGTH_BITS sets the payload counter width; lengths saturate at its top, or at the 24-bit output top if lower.
module nal_unit_start_code_splitter #(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // end_of_stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] unit_index, [47:16] stream_offset, [50:48] start_code_length,
  // [51] forbidden_flag, [53:52] reference_priority, [58:54] unit_type,
  // [82:59] payload_length, [83] length_saturated, [87:84] zero
  output logic [87:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o   // [1:0] status
);
  import nalsp_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_eos_q;
  logic       out_valid_q, out_valid_d;
  result_t    out_q;
  logic       advance;
  logic       res_valid;
  result_t    res;

  // input register moves on whenever the output register can take a result
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_valid_d      = s_axis_tready_o ? s_axis_tvalid_i : in_valid_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  nalsp_scan #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .byte_i     (in_byte_q),
    .eos_i      (in_eos_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item payloads
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_eos_q  <= s_axis_tlast_i;
    end
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {4'd0,
                            out_q.length_saturated,
                            out_q.payload_length,
                            out_q.unit_type,
                            out_q.reference_priority,
                            out_q.forbidden_flag,
                            out_q.start_code_length,
                            out_q.stream_offset,
                            out_q.unit_index};

endmodule
